// ----- src/dts_pkg.sv -----
package dts_pkg;

    // field widths fixed by the item formats
    localparam int TEMP_W  = 12;
    localparam int IDX_W   = 11;
    localparam int CEIL_W  = 9;
    localparam int MONTH_W = 4;

    localparam int DEF_MAX_SAMPLES = 2048;

    localparam logic [MONTH_W-1:0] MONTH_RESET = 4'd1;

    // ceiling adjustment
    localparam logic [CEIL_W-1:0] CEIL_STEP = 9'd50;
    localparam logic signed [TEMP_W:0] CEIL_SPAN = 13'sd300;

    // controller to datapath
    typedef struct packed {
        logic accept;   // input item taken
        logic capture;  // input item taken and it closes the day
        logic prep;     // make dividend positive, clear remainder
        logic step;     // one restoring division step
        logic load;     // move result into the output register
    } dts_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done; // current step is the final one
    } dts_status_t;

    // base ceiling per month; out-of-range months clamp to 1 or 12
    function automatic logic [CEIL_W-1:0] base_ceiling(input logic [MONTH_W-1:0] month);
        logic [CEIL_W-1:0] c;
        unique case (month)
            4'd0, 4'd1, 4'd2:       c = 9'd150;
            4'd3:                   c = 9'd200;
            4'd4:                   c = 9'd250;
            4'd5:                   c = 9'd300;
            4'd6, 4'd7, 4'd8:       c = 9'd350;
            4'd9:                   c = 9'd300;
            4'd10:                  c = 9'd250;
            4'd11:                  c = 9'd200;
            default:                c = 9'd150;
        endcase
        return c;
    endfunction

endpackage

// ----- src/dts_ctrl.sv -----
module dts_ctrl
    import dts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tlast,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  dts_status_t status,
    output dts_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;

    assign s_tready = (state_reg == ST_ACCUM);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    // commands
    always_comb
    begin
        cmd         = '0;
        cmd.accept  = accept;
        cmd.capture = accept && s_tlast;
        cmd.prep    = (state_reg == ST_PREP);
        cmd.step    = (state_reg == ST_DIV);
        cmd.load    = (state_reg == ST_DONE) && out_free;
    end

    // next state and output valid
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_ACCUM:
            begin
                if (accept && s_tlast)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- src/dts_datapath.sv -----
module dts_datapath
    import dts_pkg::*;
#(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [MONTH_W-1:0]       cfg_wdata,
    input  logic signed [TEMP_W-1:0] temperature,
    input  logic                     missing,
    input  dts_cmd_t                 cmd,
    output dts_status_t              status,
    output logic                     any_valid,
    output logic [IDX_W-1:0]         min_index,
    output logic signed [TEMP_W-1:0] min_value,
    output logic [IDX_W-1:0]         max_index,
    output logic signed [TEMP_W-1:0] max_value,
    output logic signed [TEMP_W-1:0] average,
    output logic [CEIL_W-1:0]        ceiling
);

    localparam int POS_W  = $clog2(MAX_SAMPLES + 1);
    localparam int CNT_W  = POS_W;
    localparam int SUM_W  = TEMP_W + $clog2(MAX_SAMPLES);
    localparam int STEP_W = $clog2(SUM_W);

    // month register
    logic [MONTH_W-1:0] month_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            month_reg <= MONTH_RESET;
        end
        else if (cfg_we)
        begin
            month_reg <= cfg_wdata;
        end
    end

    // running statistics
    logic [POS_W-1:0]         pos_reg, pos_next, pos_upd;
    logic signed [TEMP_W-1:0] lo_val_reg, lo_val_next, lo_val_upd;
    logic [IDX_W-1:0]         lo_pos_reg, lo_pos_next, lo_pos_upd;
    logic signed [TEMP_W-1:0] hi_val_reg, hi_val_next, hi_val_upd;
    logic [IDX_W-1:0]         hi_pos_reg, hi_pos_next, hi_pos_upd;
    logic signed [SUM_W-1:0]  sum_reg, sum_next, sum_upd;
    logic [CNT_W-1:0]         cnt_reg, cnt_next, cnt_upd;
    logic                     seen_reg, seen_next, seen_upd;
    logic                     in_range, take;
    logic [POS_W+IDX_W-1:0]   pos_wide;
    logic [IDX_W-1:0]         pos_idx;

    assign in_range = (pos_reg < POS_W'(MAX_SAMPLES));
    assign take     = cmd.accept && in_range && !missing;
    assign pos_wide = {{IDX_W{1'b0}}, pos_reg};
    assign pos_idx  = pos_wide[IDX_W-1:0];

    // statistics including the current item
    always_comb
    begin
        pos_upd    = pos_reg;
        lo_val_upd = lo_val_reg;
        lo_pos_upd = lo_pos_reg;
        hi_val_upd = hi_val_reg;
        hi_pos_upd = hi_pos_reg;
        sum_upd    = sum_reg;
        cnt_upd    = cnt_reg;
        seen_upd   = seen_reg;
        if (cmd.accept && in_range)
        begin
            pos_upd = pos_reg + 1'b1;
        end
        if (take)
        begin
            // ties go to the later position
            if (!seen_reg || temperature <= lo_val_reg)
            begin
                lo_val_upd = temperature;
                lo_pos_upd = pos_idx;
            end
            if (!seen_reg || temperature >= hi_val_reg)
            begin
                hi_val_upd = temperature;
                hi_pos_upd = pos_idx;
            end
            sum_upd  = sum_reg + {{(SUM_W-TEMP_W){temperature[TEMP_W-1]}}, temperature};
            cnt_upd  = cnt_reg + 1'b1;
            seen_upd = 1'b1;
        end
    end

    // a closing item starts a new day
    always_comb
    begin
        if (cmd.capture)
        begin
            pos_next    = '0;
            lo_val_next = '0;
            lo_pos_next = '0;
            hi_val_next = '0;
            hi_pos_next = '0;
            sum_next    = '0;
            cnt_next    = '0;
            seen_next   = 1'b0;
        end
        else
        begin
            pos_next    = pos_upd;
            lo_val_next = lo_val_upd;
            lo_pos_next = lo_pos_upd;
            hi_val_next = hi_val_upd;
            hi_pos_next = hi_pos_upd;
            sum_next    = sum_upd;
            cnt_next    = cnt_upd;
            seen_next   = seen_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            lo_val_reg <= '0;
            lo_pos_reg <= '0;
            hi_val_reg <= '0;
            hi_pos_reg <= '0;
            sum_reg    <= '0;
            cnt_reg    <= '0;
            seen_reg   <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            lo_val_reg <= lo_val_next;
            lo_pos_reg <= lo_pos_next;
            hi_val_reg <= hi_val_next;
            hi_pos_reg <= hi_pos_next;
            sum_reg    <= sum_next;
            cnt_reg    <= cnt_next;
            seen_reg   <= seen_next;
        end
    end

    // day snapshot and restoring divider
    logic                     snap_seen_reg;
    logic signed [TEMP_W-1:0] snap_lo_val_reg, snap_hi_val_reg;
    logic [IDX_W-1:0]         snap_lo_pos_reg, snap_hi_pos_reg;
    logic                     snap_neg_reg;
    logic [CNT_W-1:0]         div_d_reg;
    logic [SUM_W-1:0]         div_q_reg, div_q_next;
    logic [CNT_W-1:0]         div_r_reg, div_r_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [CNT_W:0]           rem_shift, rem_diff;

    assign rem_shift = {div_r_reg, div_q_reg[SUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, div_d_reg};
    assign status.div_done = (step_reg == STEP_W'(SUM_W - 1));

    always_comb
    begin
        div_q_next = div_q_reg;
        div_r_next = div_r_reg;
        step_next  = step_reg;
        if (cmd.capture)
        begin
            div_q_next = sum_upd;
        end
        else if (cmd.prep)
        begin
            div_q_next = snap_neg_reg ? (~div_q_reg + 1'b1) : div_q_reg;
            div_r_next = '0;
            step_next  = '0;
        end
        else if (cmd.step)
        begin
            step_next = step_reg + 1'b1;
            if (!rem_diff[CNT_W])
            begin
                div_r_next = rem_diff[CNT_W-1:0];
                div_q_next = {div_q_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                div_r_next = rem_shift[CNT_W-1:0];
                div_q_next = {div_q_reg[SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        div_q_reg <= div_q_next;
        div_r_reg <= div_r_next;
        step_reg  <= step_next;
        if (cmd.capture)
        begin
            snap_seen_reg   <= seen_upd;
            snap_lo_val_reg <= lo_val_upd;
            snap_lo_pos_reg <= lo_pos_upd;
            snap_hi_val_reg <= hi_val_upd;
            snap_hi_pos_reg <= hi_pos_upd;
            snap_neg_reg    <= sum_upd[SUM_W-1];
            div_d_reg       <= cnt_upd;
        end
    end

    // result: average sign fix and ceiling adjustment
    logic [CEIL_W-1:0]        ceil_base, ceil_up, ceil_res;
    logic signed [TEMP_W:0]   ceil_up_s, hi_ext, lo_ext;
    logic [TEMP_W-1:0]        quot;
    logic signed [TEMP_W-1:0] avg_res;

    assign ceil_base = base_ceiling(month_reg);
    assign hi_ext    = {snap_hi_val_reg[TEMP_W-1], snap_hi_val_reg};
    assign lo_ext    = {snap_lo_val_reg[TEMP_W-1], snap_lo_val_reg};
    assign quot      = div_q_reg[TEMP_W-1:0];

    always_comb
    begin
        ceil_up = ceil_base;
        if (snap_seen_reg && (hi_ext > $signed({{(TEMP_W+1-CEIL_W){1'b0}}, ceil_base})))
        begin
            ceil_up = ceil_base + CEIL_STEP;
        end
        ceil_up_s = $signed({{(TEMP_W+1-CEIL_W){1'b0}}, ceil_up});
        ceil_res  = ceil_up;
        if (snap_seen_reg && (lo_ext < (ceil_up_s - CEIL_SPAN)))
        begin
            ceil_res = ceil_up - CEIL_STEP;
        end
        if (!snap_seen_reg)
        begin
            avg_res = '0;
        end
        else if (snap_neg_reg)
        begin
            avg_res = $signed(~quot + 1'b1);
        end
        else
        begin
            avg_res = $signed(quot);
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            any_valid <= snap_seen_reg;
            min_index <= snap_seen_reg ? snap_lo_pos_reg : '0;
            min_value <= snap_seen_reg ? snap_lo_val_reg : '0;
            max_index <= snap_seen_reg ? snap_hi_pos_reg : '0;
            max_value <= snap_seen_reg ? snap_hi_val_reg : '0;
            average   <= avg_res;
            ceiling   <= ceil_res;
        end
    end

endmodule

// ----- src/day_temperature_statistics_core.sv -----
// Daily temperature statistics. Samples (tenths of a degree) stream in, one
// item per cycle; missing samples take a position but are skipped, and
// samples past MAX_SAMPLES are ignored. The item marked tlast closes the day
// and produces one result: newest min/max with positions, the average
// truncated toward zero (tuser low when no sample was valid), and the
// diagram ceiling from the month table with its +50/-50 adjustment. After a
// closing item the input stalls while a restoring divider works out the
// average one quotient bit per cycle, plus any wait for the previous result
// to be taken. Otherwise the input takes one item every cycle, also while a
// result waits. The month is written through cfg_we/cfg_wdata; the user must
// write it only while the block is idle, as the block does not enforce it.
module day_temperature_statistics_core
    import dts_pkg::*;
#(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [3:0]   cfg_wdata,  // month
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,    // [11:0] temperature, [15:12] zero
    input  logic [0:0]   s_tuser,    // [0] missing
    input  logic         s_tlast,    // last sample of the day
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,    // min_index, min_value, max_index, max_value,
                                     // average, ceiling, zero fill
    output logic [0:0]   m_tuser     // [0] any_valid
);

    dts_cmd_t                 cmd;
    dts_status_t              status;
    logic                     any_valid;
    logic [IDX_W-1:0]         min_index, max_index;
    logic signed [TEMP_W-1:0] min_value, max_value, average;
    logic [CEIL_W-1:0]        ceiling;

    dts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dts_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .temperature ($signed(s_tdata[TEMP_W-1:0])),
        .missing     (s_tuser[0]),
        .cmd         (cmd),
        .status      (status),
        .any_valid   (any_valid),
        .min_index   (min_index),
        .min_value   (min_value),
        .max_index   (max_index),
        .max_value   (max_value),
        .average     (average),
        .ceiling     (ceiling)
    );

    // pack result fields, lowest first
    assign m_tdata = {5'd0, ceiling, average, max_value, max_index, min_value, min_index};
    assign m_tuser = any_valid;

endmodule
